@@ rtl/core/msht_pkg.sv @@
`timescale 1ns / 1ps
package msht_pkg;

   // field widths
   localparam int KEY_W   = 16;
   localparam int SQ_W    = 32;
   localparam int DIGITS  = 10;
   localparam int DIGIT_W = 4;
   localparam int BCD_W   = DIGITS * DIGIT_W;
   localparam int MID_W   = 7;
   localparam int SLOT_W  = 7;
   localparam int TS_W    = 8;
   localparam int CONV_W  = 5;
   localparam int MODC_W  = 3;

   // table size after reset
   localparam logic [TS_W-1:0] TS_RESET = 8'd128;

   // request codes
   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_SEARCH = 2'd2
   } req_type_type;

   // controller to datapath
   typedef struct packed {
      logic clr_step;
      logic load;
      logic conv_step;
      logic pick;
      logic mod_step;
      logic mem_rd;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_done;
      logic conv_done;
      logic mod_done;
      logic out_free;
   } status_type;

endpackage

@@ rtl/core/msht_ctrl.sv @@
`timescale 1ns / 1ps
module msht_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  msht_pkg::status_type status,
   output msht_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_CONV   = 7'b0000100,
      ST_PICK   = 7'b0001000,
      ST_MOD    = 7'b0010000,
      ST_READ   = 7'b0100000,
      ST_UPDATE = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (status.conv_done) state_in = ST_PICK;
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_done) state_in = ST_READ;
         end
         ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

@@ rtl/core/msht_datapath.sv @@
`timescale 1ns / 1ps
module msht_datapath #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  msht_pkg::cmd_type                cmd,
   output msht_pkg::status_type             status,
   input  logic [1:0]                       req_type,
   input  logic [msht_pkg::KEY_W-1:0]       req_key,
   input  logic                             csr_we,
   input  logic [msht_pkg::TS_W-1:0]        csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_found,
   output logic [msht_pkg::SLOT_W-1:0]      rsp_slot
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // request registers
   msht_pkg::req_type_type             type_ff;
   logic [msht_pkg::KEY_W-1:0]         key_ff;

   // binary to decimal conversion
   logic [msht_pkg::SQ_W-1:0]          bin_ff;
   logic [msht_pkg::SQ_W-1:0]          bin_in;
   logic [msht_pkg::BCD_W-1:0]         bcd_ff;
   logic [msht_pkg::BCD_W-1:0]         bcd_in;
   logic [msht_pkg::BCD_W-1:0]         bcd_adj;
   logic [msht_pkg::CONV_W-1:0]        conv_cnt_ff;

   // middle digits and remainder
   logic [msht_pkg::DIGIT_W-1:0]       dig [msht_pkg::DIGITS];
   logic [3:0]                         len;
   logic [3:0]                         half;
   logic [msht_pkg::DIGIT_W-1:0]       dig_hi;
   logic [msht_pkg::DIGIT_W-1:0]       dig_lo;
   logic [msht_pkg::MID_W-1:0]         mid_in;
   logic [msht_pkg::MID_W-1:0]         mid_ff;
   logic [msht_pkg::MODC_W-1:0]        mod_cnt_ff;
   logic [msht_pkg::TS_W-1:0]          rem_ff;
   logic [msht_pkg::TS_W-1:0]          rem_in;
   logic [msht_pkg::TS_W:0]            trial;
   logic [msht_pkg::TS_W-1:0]          table_size_ff;
   logic [msht_pkg::TS_W-1:0]          divisor;

   // table store
   logic [msht_pkg::KEY_W-1:0]         mem [TABLE_DEPTH];
   logic [msht_pkg::KEY_W-1:0]         rdata_ff;
   logic [IDX_W-1:0]                   clr_ff;
   logic [IDX_W-1:0]                   slot_addr;
   logic                               mem_we;
   logic [IDX_W-1:0]                   mem_waddr;
   logic [msht_pkg::KEY_W-1:0]         mem_wdata;
   logic                               match;
   logic                               found_in;

   // output register
   logic                               rsp_valid_ff;
   logic                               found_ff;
   logic [msht_pkg::SLOT_W-1:0]        slot_ff;

   // table size register
   always_ff @(posedge clock) begin
      if (reset)       table_size_ff <= msht_pkg::TS_RESET;
      else if (csr_we) table_size_ff <= csr_wdata;
   end

   // effective divisor: zero counts as one, capped at the depth
   always_comb begin
      if (table_size_ff == '0)
         divisor = msht_pkg::TS_W'(1);
      else if (32'(table_size_ff) > TABLE_DEPTH)
         divisor = msht_pkg::TS_W'(TABLE_DEPTH);
      else
         divisor = table_size_ff;
   end

   // double dabble step: add 3 to digits of 5 and up, then shift in one bit
   always_comb begin
      bcd_adj = bcd_ff;
      for (int k = 0; k < msht_pkg::DIGITS; k++) begin
         if (bcd_ff[k*msht_pkg::DIGIT_W +: msht_pkg::DIGIT_W] >= 4'd5)
            bcd_adj[k*msht_pkg::DIGIT_W +: msht_pkg::DIGIT_W] =
               bcd_ff[k*msht_pkg::DIGIT_W +: msht_pkg::DIGIT_W] + 4'd3;
      end
      bcd_in = {bcd_adj[msht_pkg::BCD_W-2:0], bin_ff[msht_pkg::SQ_W-1]};
      bin_in = {bin_ff[msht_pkg::SQ_W-2:0], 1'b0};
   end

   // digit count and middle digit selection
   always_comb begin
      for (int k = 0; k < msht_pkg::DIGITS; k++)
         dig[k] = bcd_ff[k*msht_pkg::DIGIT_W +: msht_pkg::DIGIT_W];
      len = 4'd1;
      for (int k = 1; k < msht_pkg::DIGITS; k++) begin
         if (dig[k] != '0) len = 4'(k + 1);
      end
      half   = len >> 1;
      dig_hi = dig[half];
      dig_lo = (half == '0) ? '0 : dig[half - 4'd1];
      if (len[0])
         mid_in = msht_pkg::MID_W'(dig_hi);
      else
         mid_in = msht_pkg::MID_W'({dig_hi, 3'b000}) + msht_pkg::MID_W'({dig_hi, 1'b0})
                  + msht_pkg::MID_W'(dig_lo);
   end

   // restoring remainder step, one bit of the middle value per cycle
   always_comb begin
      trial = {rem_ff, mid_ff[mod_cnt_ff]};
      if (trial >= {1'b0, divisor})
         rem_in = msht_pkg::TS_W'(trial - {1'b0, divisor});
      else
         rem_in = trial[msht_pkg::TS_W-1:0];
   end

   // hash pipeline registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff     <= msht_pkg::req_type_type'(req_type);
         key_ff      <= req_key;
         bin_ff      <= msht_pkg::SQ_W'(req_key) * msht_pkg::SQ_W'(req_key);
         bcd_ff      <= '0;
         conv_cnt_ff <= '0;
      end else if (cmd.conv_step) begin
         bin_ff      <= bin_in;
         bcd_ff      <= bcd_in;
         conv_cnt_ff <= conv_cnt_ff + 1'b1;
      end
      if (cmd.pick) begin
         mid_ff     <= mid_in;
         rem_ff     <= '0;
         mod_cnt_ff <= msht_pkg::MODC_W'(msht_pkg::MID_W - 1);
      end else if (cmd.mod_step) begin
         rem_ff     <= rem_in;
         mod_cnt_ff <= mod_cnt_ff - 1'b1;
      end
   end

   assign slot_addr = IDX_W'(rem_ff);
   assign match     = (rdata_ff == key_ff);

   // table update and result for the finished item
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot_addr;
      mem_wdata = key_ff;
      found_in  = 1'b0;
      if (cmd.clr_step) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (cmd.commit) begin
         case (type_ff)
            msht_pkg::REQ_INSERT: begin
               mem_we   = 1'b1;
               found_in = 1'b1;
            end
            msht_pkg::REQ_DELETE: begin
               mem_we    = match;
               mem_wdata = '0;
               found_in  = match;
            end
            msht_pkg::REQ_SEARCH: begin
               found_in = match;
            end
            default: begin
               found_in = 1'b0;
            end
         endcase
      end
   end

   // table memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (cmd.mem_rd) rdata_ff <= mem[slot_addr];
   end

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset)             clr_ff <= '0;
      else if (cmd.clr_step) clr_ff <= clr_ff + 1'b1;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)           rsp_valid_ff <= 1'b0;
      else if (cmd.commit) rsp_valid_ff <= 1'b1;
      else if (rsp_ready)  rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         found_ff <= found_in;
         slot_ff  <= rem_ff[msht_pkg::SLOT_W-1:0];
      end
   end

   assign status.clr_done  = (clr_ff == IDX_W'(TABLE_DEPTH - 1));
   assign status.conv_done = (conv_cnt_ff == msht_pkg::CONV_W'(msht_pkg::SQ_W - 1));
   assign status.mod_done  = (mod_cnt_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = found_ff;
   assign rsp_slot  = slot_ff;

endmodule

@@ rtl/core/mid_square_hash_table_top.sv @@
`timescale 1ns / 1ps
// Direct-mapped hash table of TABLE_DEPTH 16-bit slots, indexed by the decimal
// mid-square hash of the key, with no collision handling. Each request item
// (insert, delete or search) gives one result item: found and the slot index.
// One item is worked at a time: the key is squared as it is loaded, then 32
// double-dabble steps in the binary-to-decimal converter, a pick of the middle
// digits, 7 steps of the bit-serial remainder unit, a memory read and an update
// that also loads the result register, then the idle state in which the next
// item is accepted. A result that is not taken holds the update until the
// result register frees. After reset the table is swept to empty, one slot at
// a time, while req_tready is low.
// The csr channel is always ready and sets the table size used as divisor.
module mid_square_hash_table_top #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] key
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] found, [7:1] slot_index
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // [7:0] table_size
);

   msht_pkg::cmd_type    cmd;
   msht_pkg::status_type status;
   logic                 rsp_found;
   logic [6:0]           rsp_slot;

   // sequencer
   msht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // hash unit, table store and result register
   msht_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_type  (req_tuser),
      .req_key   (req_tdata),
      .csr_we    (csr_valid),
      .csr_wdata (csr_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_found (rsp_found),
      .rsp_slot  (rsp_slot)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = {rsp_slot, rsp_found};

endmodule

@@ rtl/core/msht_checker.sv @@
`timescale 1ns / 1ps
module msht_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // a held result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // an accepted item is worked alone, so no accept right after another
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while hashing");

   // the mid-square value is below one hundred, so is the slot
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] < 7'd100)
      else $error("slot index out of range");

   // reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind mid_square_hash_table_top msht_checker u_msht_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
